@@ rtl/ps2m_pkg.sv @@
package ps2m_pkg;

  // link phases
  typedef enum logic [2:0] {
    PH_UNINIT    = 3'd0,
    PH_AWAIT_ACK = 3'd1,
    PH_SELFTEST  = 3'd2,
    PH_AWAIT_ID  = 3'd3,
    PH_DETECT    = 3'd4,
    PH_SETUP     = 3'd5,
    PH_RUN       = 3'd6
  } phase_t;

  // detected mouse type
  typedef enum logic [1:0] {
    MK_UNKNOWN = 2'd0,
    MK_STD     = 2'd1,
    MK_WHEEL   = 2'd2,
    MK_FIVE    = 2'd3
  } mouse_kind_t;

  // ps/2 command and response codes
  localparam logic [7:0] C_RESET   = 8'hFF;
  localparam logic [7:0] C_RESEND  = 8'hFE;
  localparam logic [7:0] C_ACK     = 8'hFA;
  localparam logic [7:0] C_BAT_OK  = 8'hAA;
  localparam logic [7:0] C_GET_ID  = 8'hF2;
  localparam logic [7:0] C_SETRATE = 8'hF3;
  localparam logic [7:0] C_SETRES  = 8'hE8;
  localparam logic [7:0] C_SCALE11 = 8'hE6;
  localparam logic [7:0] C_ENABLE  = 8'hF4;

  // device ids
  localparam logic [7:0] ID_STD   = 8'h00;
  localparam logic [7:0] ID_WHEEL = 8'h03;
  localparam logic [7:0] ID_FIVE  = 8'h04;

  // knock sample rates
  localparam logic [7:0] RATE_200 = 8'd200;
  localparam logic [7:0] RATE_100 = 8'd100;
  localparam logic [7:0] RATE_80  = 8'd80;

  // packet lengths
  localparam logic [2:0] PLEN_STD = 3'd3;
  localparam logic [2:0] PLEN_EXT = 3'd4;

  // input transaction codes
  localparam logic       ACT_BYTE    = 1'b0;
  localparam logic       ACT_TICK    = 1'b1;
  localparam logic [1:0] FS_GOOD     = 2'd0;
  localparam logic [1:0] FS_FRAMING  = 2'd1;
  localparam logic [1:0] FS_PARITY   = 2'd2;
  localparam logic [1:0] FS_RESERVED = 2'd3;

  // result kinds
  localparam logic RK_COMMAND = 1'b0;
  localparam logic RK_REPORT  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_STALL_LIMIT = 2'd0;
  localparam logic [1:0] CFG_RESOLUTION  = 2'd1;
  localparam logic [1:0] CFG_REPORT_RATE = 2'd2;

  // configuration reset values
  localparam logic [7:0] STALL_LIMIT_RST = 8'd5;
  localparam logic [1:0] RESOLUTION_RST  = 2'd3;
  localparam logic [7:0] REPORT_RATE_RST = 8'd40;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [1:0] frame_status;
    logic       clock_high;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        command_byte;
    logic [4:0]        button_bits;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [3:0] move_wheel;
  } result_t;

  // 9-bit two's complement movement clamped to +-127
  function automatic logic [7:0] xy_clamp(input logic [7:0] mag, input logic sgn);
    logic [7:0] v;
    if (sgn) begin
      v = (mag < 8'd129) ? 8'h81 : mag;
    end else begin
      v = (mag > 8'd127) ? 8'h7F : mag;
    end
    return v;
  endfunction

endpackage

@@ rtl/ps2m_if.sv @@
interface ps2m_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic [1:0] frame_status;
  logic       clock_high;

  modport source(output valid, action, rx_byte, frame_status, clock_high, input ready);
  modport sink(input valid, action, rx_byte, frame_status, clock_high, output ready);
endinterface

interface ps2m_out_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        command_byte;
  logic [4:0]        button_bits;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;
  logic signed [3:0] move_wheel;

  modport source(output valid, kind, command_byte, button_bits, move_x, move_y,
                 move_wheel, input ready);
  modport sink(input valid, kind, command_byte, button_bits, move_x, move_y,
               move_wheel, output ready);
endinterface

@@ rtl/ps2m_in_reg.sv @@
module ps2m_in_reg
  import ps2m_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  ps2m_in_if.sink in_ch,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  take;

  // take a new transaction when empty or when the held one moves on
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (take) begin
      valid_nxt             = 1'b1;
      item_nxt.action       = in_ch.action;
      item_nxt.rx_byte      = in_ch.rx_byte;
      item_nxt.frame_status = in_ch.frame_status;
      item_nxt.clock_high   = in_ch.clock_high;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/ps2m_ctrl.sv @@
module ps2m_ctrl
  import ps2m_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  item_t      item,
  input  logic       out_free,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       advance,
  output logic       res_load,
  output result_t    res
);

  // configuration
  logic [7:0] stall_limit_r;
  logic [1:0] resolution_r;
  logic [7:0] report_rate_r;

  // link state
  phase_t      phase_r, phase_nxt;
  mouse_kind_t kind_r, kind_nxt;
  logic [2:0]  knock_r, knock_nxt;
  logic [2:0]  setup_r, setup_nxt;
  logic [1:0]  pidx_r, pidx_nxt;
  logic [2:0]  plen_r, plen_nxt;
  logic [4:0]  btn_r, btn_nxt;
  logic [3:0]  sof_r, sof_nxt;
  logic [7:0]  hx_r, hx_nxt;
  logic [7:0]  hy_r, hy_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [7:0]  stall_r, stall_nxt;

  logic       has_res;
  logic [7:0] b;
  logic [7:0] stall_inc;
  logic       ovf;
  logic [2:0] pnext;

  assign advance   = item_valid && out_free;
  assign res_load  = advance && has_res;
  assign b         = item.rx_byte;
  assign stall_inc = stall_r + 8'd1;
  assign ovf       = sof_r[3:2] != 2'b00;
  assign pnext     = {1'b0, pidx_r} + 3'd1;

  // next state and result for the held transaction
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    knock_nxt = knock_r;
    setup_nxt = setup_r;
    pidx_nxt  = pidx_r;
    plen_nxt  = plen_r;
    btn_nxt   = btn_r;
    sof_nxt   = sof_r;
    hx_nxt    = hx_r;
    hy_nxt    = hy_r;
    hw_nxt    = hw_r;
    stall_nxt = stall_r;
    has_res   = 1'b0;
    res       = '0;
    res.kind  = RK_COMMAND;

    if (item.action == ACT_TICK) begin
      // detect-interval tick, ignored once the link is up
      if (phase_r != PH_RUN) begin
        if (item.clock_high) begin
          if (stall_inc > stall_limit_r) begin
            kind_nxt         = MK_UNKNOWN;
            phase_nxt        = PH_AWAIT_ACK;
            stall_nxt        = 8'd0;
            has_res          = 1'b1;
            res.command_byte = C_RESET;
          end else begin
            stall_nxt = stall_inc;
          end
        end else if (phase_r == PH_UNINIT) begin
          stall_nxt = 8'd0;
        end
      end
    end else if (item.frame_status != FS_GOOD) begin
      // frame error drops the link
      phase_nxt = PH_UNINIT;
      kind_nxt  = MK_UNKNOWN;
      if (item.frame_status == FS_PARITY) begin
        has_res          = 1'b1;
        res.command_byte = C_RESEND;
      end
    end else begin
      unique case (phase_r)
        PH_UNINIT, PH_SELFTEST: begin
          if (b == C_BAT_OK) begin
            kind_nxt  = MK_UNKNOWN;
            phase_nxt = PH_AWAIT_ID;
          end else begin
            phase_nxt        = PH_AWAIT_ACK;
            has_res          = 1'b1;
            res.command_byte = C_RESET;
          end
        end
        PH_AWAIT_ACK: begin
          if (b == C_ACK) begin
            phase_nxt = PH_SELFTEST;
          end else begin
            has_res          = 1'b1;
            res.command_byte = C_RESET;
          end
        end
        PH_AWAIT_ID: begin
          if (b == C_ACK) begin
            has_res = 1'b0;
          end else if (b == ID_STD) begin
            has_res = 1'b1;
            if (kind_r == MK_UNKNOWN) begin
              kind_nxt         = MK_STD;
              knock_nxt        = 3'd0;
              phase_nxt        = PH_DETECT;
              res.command_byte = C_SETRATE;
            end else begin
              kind_nxt         = MK_STD;
              plen_nxt         = PLEN_STD;
              setup_nxt        = 3'd0;
              phase_nxt        = PH_SETUP;
              res.command_byte = C_SETRES;
            end
          end else if (b == ID_WHEEL) begin
            has_res = 1'b1;
            if (kind_r == MK_STD) begin
              kind_nxt         = MK_WHEEL;
              phase_nxt        = PH_DETECT;
              res.command_byte = C_SETRATE;
            end else begin
              kind_nxt         = MK_WHEEL;
              plen_nxt         = PLEN_EXT;
              setup_nxt        = 3'd0;
              phase_nxt        = PH_SETUP;
              res.command_byte = C_SETRES;
            end
          end else if (b == ID_FIVE) begin
            has_res          = 1'b1;
            kind_nxt         = MK_FIVE;
            plen_nxt         = PLEN_EXT;
            setup_nxt        = 3'd0;
            phase_nxt        = PH_SETUP;
            res.command_byte = C_SETRES;
          end else begin
            phase_nxt        = PH_AWAIT_ACK;
            has_res          = 1'b1;
            res.command_byte = C_RESET;
          end
        end
        PH_DETECT: begin
          if (b != C_ACK) begin
            // knock refused: fall back to a standard mouse
            knock_nxt        = 3'd0;
            kind_nxt         = MK_STD;
            plen_nxt         = PLEN_STD;
            setup_nxt        = 3'd0;
            phase_nxt        = PH_SETUP;
            has_res          = 1'b1;
            res.command_byte = C_SETRES;
          end else begin
            // knock sequence step counter
            has_res = 1'b1;
            case (knock_r)
              3'd0: begin
                knock_nxt = 3'd1; res.command_byte = RATE_200;
              end
              3'd1: begin
                knock_nxt = 3'd2; res.command_byte = C_SETRATE;
              end
              3'd2: begin
                knock_nxt        = 3'd3;
                res.command_byte = (kind_r == MK_WHEEL) ? RATE_200 : RATE_100;
              end
              3'd3: begin
                knock_nxt = 3'd4; res.command_byte = C_SETRATE;
              end
              3'd4: begin
                knock_nxt = 3'd5; res.command_byte = RATE_80;
              end
              3'd5: begin
                knock_nxt        = 3'd0;
                phase_nxt        = PH_AWAIT_ID;
                res.command_byte = C_GET_ID;
              end
              default: has_res = 1'b0;
            endcase
          end
        end
        PH_SETUP: begin
          if (b == C_ACK) begin
            has_res = 1'b1;
            case (setup_r)
              3'd0: begin
                setup_nxt = 3'd1; res.command_byte = {6'd0, resolution_r};
              end
              3'd1: begin
                setup_nxt = 3'd2; res.command_byte = C_SCALE11;
              end
              3'd2: begin
                setup_nxt = 3'd3; res.command_byte = C_SETRATE;
              end
              3'd3: begin
                setup_nxt = 3'd4; res.command_byte = report_rate_r;
              end
              3'd4: begin
                setup_nxt = 3'd5; res.command_byte = C_ENABLE;
              end
              default: begin
                // enable acknowledged: link is up
                has_res   = 1'b0;
                setup_nxt = 3'd0;
                phase_nxt = PH_RUN;
                pidx_nxt  = 2'd0;
                btn_nxt   = {2'b00, btn_r[2:0]};
                hw_nxt    = 4'd0;
              end
            endcase
          end
        end
        PH_RUN: begin
          // packet assembly
          case (pidx_r)
            2'd0: begin
              btn_nxt = {btn_r[4:3], b[2:0]};
              sof_nxt = b[7:4];
            end
            2'd1: begin
              hx_nxt = ovf ? 8'd0 : xy_clamp(b, sof_r[0]);
            end
            2'd2: begin
              sof_nxt = sof_r ^ 4'b0010;
              hy_nxt  = ovf ? 8'd0 : xy_clamp(~b, ~sof_r[1]);
            end
            default: begin
              if (kind_r == MK_WHEEL) begin
                hw_nxt = b[3:0];
              end else if (kind_r == MK_FIVE) begin
                btn_nxt = {b[5:4], btn_r[2:0]};
                hw_nxt  = b[3:0];
              end
            end
          endcase
          if (pnext >= plen_r) begin
            pidx_nxt        = 2'd0;
            has_res         = 1'b1;
            res.kind        = RK_REPORT;
            res.button_bits = btn_nxt;
            res.move_x      = hx_nxt;
            res.move_y      = hy_nxt;
            res.move_wheel  = hw_nxt;
          end else begin
            pidx_nxt = pnext[1:0];
          end
        end
        default: has_res = 1'b0;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_limit_r <= STALL_LIMIT_RST;
      resolution_r  <= RESOLUTION_RST;
      report_rate_r <= REPORT_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STALL_LIMIT: stall_limit_r <= cfg_data;
        CFG_RESOLUTION:  resolution_r  <= cfg_data[1:0];
        CFG_REPORT_RATE: report_rate_r <= cfg_data;
        default:         stall_limit_r <= stall_limit_r;
      endcase
    end
  end

  // link state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_UNINIT;
      kind_r  <= MK_UNKNOWN;
      knock_r <= 3'd0;
      setup_r <= 3'd0;
      pidx_r  <= 2'd0;
      plen_r  <= 3'd0;
      btn_r   <= 5'd0;
      sof_r   <= 4'd0;
      hx_r    <= 8'd0;
      hy_r    <= 8'd0;
      hw_r    <= 4'd0;
      stall_r <= 8'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      knock_r <= knock_nxt;
      setup_r <= setup_nxt;
      pidx_r  <= pidx_nxt;
      plen_r  <= plen_nxt;
      btn_r   <= btn_nxt;
      sof_r   <= sof_nxt;
      hx_r    <= hx_nxt;
      hy_r    <= hy_nxt;
      hw_r    <= hw_nxt;
      stall_r <= stall_nxt;
    end
  end

  // running link always has a valid packet length
  a_run_plen: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RUN) |-> (plen_r == PLEN_STD || plen_r == PLEN_EXT))
    else $error("packet length invalid while link is up");

  // packet index stays inside the packet
  a_run_pidx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RUN) |-> ({1'b0, pidx_r} < plen_r))
    else $error("packet index beyond packet length");

  // detection only runs once a standard id has been seen
  a_detect_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DETECT) |-> (kind_r == MK_STD || kind_r == MK_WHEEL))
    else $error("detection running with no mouse kind");

  // link state moves only with a processed transaction
  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(phase_r) && $stable(pidx_r) && $stable(stall_r))
    else $error("link state changed without a transaction");

endmodule

@@ rtl/ps2m_out_reg.sv @@
module ps2m_out_reg
  import ps2m_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t data,
  output logic    out_free,
  ps2m_out_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  // slot is free when empty or being drained this cycle
  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = data;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = data_r.kind;
  assign out_ch.command_byte = data_r.command_byte;
  assign out_ch.button_bits  = data_r.button_bits;
  assign out_ch.move_x       = data_r.move_x;
  assign out_ch.move_y       = data_r.move_y;
  assign out_ch.move_wheel   = data_r.move_wheel;

endmodule

@@ rtl/ps2m_mouse_host_controller.sv @@
// PS/2 mouse host controller. Each input transaction is either a received
// frame (byte plus framing status) or a detect-interval tick; each produces
// at most one result: a command byte to transmit or a movement report
// (buttons, clamped X and inverted Y, wheel). The controller resets the mouse,
// waits for self-test, reads the ID, runs the sample-rate knocks to tell
// standard, wheel and five-button mice apart, configures resolution, scaling,
// rate and enable, then assembles 3- or 4-byte packets. One transaction is
// accepted every clock cycle while results drain; a transaction is registered on
// entry, handled in one pass of logic against the link state, and its result
// lands in the output register. Back pressure on the result channel stalls the
// input after one held transaction. Configuration registers (0 stall limit, 1
// resolution code, 2 report rate) are written via cfg_we/cfg_index/cfg_data by
// the user only while the block is idle; the block does not enforce this.
module ps2_mouse_host_controller
  import ps2m_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ps2m_in_if.sink    in_ch,
  ps2m_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic    advance;
  logic    item_valid;
  item_t   item;
  logic    out_free;
  logic    res_load;
  result_t res;

  // input register
  ps2m_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // link control and packet assembly
  ps2m_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (advance),
    .res_load   (res_load),
    .res        (res)
  );

  // result register
  ps2m_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_load),
    .data     (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

@@ tb/ps2_mouse_host_controller_tb.sv @@
`timescale 1ns / 100ps

module ps2_mouse_host_controller_tb;
  import ps2m_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  ps2m_in_if  in_ch();
  ps2m_out_if out_ch();

  ps2_mouse_host_controller u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

  // frames and ticks waiting to be driven, and the commands/reports they should cause
  item_t   link_events[$];
  item_t   sess_q[$];
  result_t due_results[$];
  int      events_queued = 0;
  int      events_taken = 0;
  int      err_cnt = 0;
  bit      in_fire = 1'b0;

  // traffic shaping knobs
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;
  bit      rx_hold = 1'b0;
  bit      hold_go = 1'b0;

  // host link state as predicted
  phase_t      lk_phase;
  mouse_kind_t lk_kind;
  logic [2:0]  knock_idx;
  logic [2:0]  setup_idx;
  logic [1:0]  pkt_idx;
  logic [2:0]  pkt_len;
  logic [4:0]  btn;
  logic [3:0]  flags;
  logic [7:0]  hx;
  logic [7:0]  hy;
  logic [3:0]  hw;
  logic [7:0]  stall_cnt;
  logic [7:0]  stall_lim;
  logic [1:0]  res_code;
  logic [7:0]  rate_arg;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("mismatch: %s", msg);
  endtask

  function automatic void model_reset();
    lk_phase  = PH_UNINIT;
    lk_kind   = MK_UNKNOWN;
    knock_idx = '0;
    setup_idx = '0;
    pkt_idx   = '0;
    pkt_len   = '0;
    btn       = '0;
    flags     = '0;
    hx        = '0;
    hy        = '0;
    hw        = '0;
    stall_cnt = '0;
    stall_lim = STALL_LIMIT_RST;
    res_code  = RESOLUTION_RST;
    rate_arg  = REPORT_RATE_RST;
  endfunction

  function automatic result_t cmd_out(input logic [7:0] code);
    result_t r;
    r = '0;
    r.kind = RK_COMMAND;
    r.command_byte = code;
    return r;
  endfunction

  // sign bit plus 8 low bits (9-bit two's complement), limited to +-127
  function automatic logic [7:0] clamp_move(input logic [7:0] mag, input logic neg);
    int v;
    v = mag;
    if (neg) v = v - 256;
    if (v > 127) v = 127;
    if (v < -127) v = -127;
    return v[7:0];
  endfunction

  function automatic void begin_setup(input mouse_kind_t k, input logic [2:0] len);
    lk_kind   = k;
    pkt_len   = len;
    setup_idx = '0;
    lk_phase  = PH_SETUP;
  endfunction

  // one frame or tick into the host link, at most one command or report out
  function automatic void host_step(input item_t ev, output bit made, output result_t res);
    logic [7:0] b;
    logic       ovf;
    logic [2:0] nxt;
    made = 1'b0;
    res  = '0;
    b    = ev.rx_byte;
    if (ev.action == ACT_TICK) begin
      // idle clock watchdog, off once the link is up
      if (lk_phase != PH_RUN) begin
        if (ev.clock_high) begin
          stall_cnt = stall_cnt + 8'd1;
          if (stall_cnt > stall_lim) begin
            lk_kind   = MK_UNKNOWN;
            lk_phase  = PH_AWAIT_ACK;
            stall_cnt = '0;
            made = 1'b1; res = cmd_out(C_RESET);
          end
        end else if (lk_phase == PH_UNINIT) begin
          stall_cnt = '0;
        end
      end
    end else if (ev.frame_status != FS_GOOD) begin
      // framing trouble drops the link
      lk_phase = PH_UNINIT;
      lk_kind  = MK_UNKNOWN;
      if (ev.frame_status == FS_PARITY) begin
        made = 1'b1; res = cmd_out(C_RESEND);
      end
    end else begin
      case (lk_phase)
        PH_UNINIT, PH_SELFTEST: begin
          if (b == C_BAT_OK) begin
            lk_kind  = MK_UNKNOWN;
            lk_phase = PH_AWAIT_ID;
          end else begin
            lk_phase = PH_AWAIT_ACK;
            made = 1'b1; res = cmd_out(C_RESET);
          end
        end
        PH_AWAIT_ACK: begin
          if (b == C_ACK) begin
            lk_phase = PH_SELFTEST;
          end else begin
            made = 1'b1; res = cmd_out(C_RESET);
          end
        end
        PH_AWAIT_ID: begin
          // id decides between another knock and final setup
          if (b == ID_STD) begin
            if (lk_kind == MK_UNKNOWN) begin
              lk_kind   = MK_STD;
              knock_idx = '0;
              lk_phase  = PH_DETECT;
              made = 1'b1; res = cmd_out(C_SETRATE);
            end else begin
              begin_setup(MK_STD, PLEN_STD);
              made = 1'b1; res = cmd_out(C_SETRES);
            end
          end else if (b == ID_WHEEL) begin
            if (lk_kind == MK_STD) begin
              lk_kind  = MK_WHEEL;
              lk_phase = PH_DETECT;
              made = 1'b1; res = cmd_out(C_SETRATE);
            end else begin
              begin_setup(MK_WHEEL, PLEN_EXT);
              made = 1'b1; res = cmd_out(C_SETRES);
            end
          end else if (b == ID_FIVE) begin
            begin_setup(MK_FIVE, PLEN_EXT);
            made = 1'b1; res = cmd_out(C_SETRES);
          end else if (b != C_ACK) begin
            lk_phase = PH_AWAIT_ACK;
            made = 1'b1; res = cmd_out(C_RESET);
          end
        end
        PH_DETECT: begin
          // sample-rate knock sequence
          if (b != C_ACK) begin
            knock_idx = '0;
            begin_setup(MK_STD, PLEN_STD);
            made = 1'b1; res = cmd_out(C_SETRES);
          end else begin
            case (knock_idx)
              3'd0: begin knock_idx = 3'd1; made = 1'b1; res = cmd_out(RATE_200); end
              3'd1: begin knock_idx = 3'd2; made = 1'b1; res = cmd_out(C_SETRATE); end
              3'd2: begin
                knock_idx = 3'd3;
                made = 1'b1;
                res = cmd_out((lk_kind == MK_WHEEL) ? RATE_200 : RATE_100);
              end
              3'd3: begin knock_idx = 3'd4; made = 1'b1; res = cmd_out(C_SETRATE); end
              3'd4: begin knock_idx = 3'd5; made = 1'b1; res = cmd_out(RATE_80); end
              3'd5: begin
                knock_idx = '0;
                lk_phase  = PH_AWAIT_ID;
                made = 1'b1; res = cmd_out(C_GET_ID);
              end
              default: ;
            endcase
          end
        end
        PH_SETUP: begin
          // final configuration, one step per ack
          if (b == C_ACK) begin
            case (setup_idx)
              3'd0: begin setup_idx = 3'd1; made = 1'b1; res = cmd_out({6'd0, res_code}); end
              3'd1: begin setup_idx = 3'd2; made = 1'b1; res = cmd_out(C_SCALE11); end
              3'd2: begin setup_idx = 3'd3; made = 1'b1; res = cmd_out(C_SETRATE); end
              3'd3: begin setup_idx = 3'd4; made = 1'b1; res = cmd_out(rate_arg); end
              3'd4: begin setup_idx = 3'd5; made = 1'b1; res = cmd_out(C_ENABLE); end
              default: begin
                setup_idx = '0;
                lk_phase  = PH_RUN;
                pkt_idx   = '0;
                btn       = btn & 5'h07;
                hw        = '0;
              end
            endcase
          end
        end
        PH_RUN: begin
          // packet assembly
          ovf = |flags[3:2];
          case (pkt_idx)
            2'd0: begin
              btn   = {btn[4:3], b[2:0]};
              flags = b[7:4];
            end
            2'd1: hx = ovf ? 8'h00 : clamp_move(b, flags[0]);
            2'd2: begin
              flags[1] = ~flags[1];
              hy = ovf ? 8'h00 : clamp_move(~b, flags[1]);
            end
            default: begin
              if (lk_kind == MK_WHEEL) begin
                hw = b[3:0];
              end else if (lk_kind == MK_FIVE) begin
                btn = {b[5:4], btn[2:0]};
                hw  = b[3:0];
              end
            end
          endcase
          nxt = {1'b0, pkt_idx} + 3'd1;
          if (nxt >= pkt_len) begin
            pkt_idx = '0;
            made = 1'b1;
            res.kind        = RK_REPORT;
            res.button_bits = btn;
            res.move_x      = hx;
            res.move_y      = hy;
            res.move_wheel  = hw;
          end else begin
            pkt_idx = nxt[1:0];
          end
        end
        default: ;
      endcase
    end
  endfunction

  // input driver
  always @(negedge clk) begin : drive_in
    item_t ev;
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (link_events.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        ev = link_events.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.action       <= ev.action;
        in_ch.rx_byte      <= ev.rx_byte;
        in_ch.frame_status <= ev.frame_status;
        in_ch.clock_high   <= ev.clock_high;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result back pressure
  always @(negedge clk) begin
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // long receiver hold, counted here while the sender keeps offering
  initial begin : hold_ctl
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // monitor: check results, predict on accepted transactions
  always @(posedge clk) begin : watch
    item_t   seen;
    result_t want;
    result_t pred;
    bit      has;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d cmd %h with nothing expected",
                                  out_ch.kind, out_ch.command_byte));
      end else begin
        want = due_results.pop_front();
        if (out_ch.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_ch.kind, want.kind));
        if (out_ch.command_byte !== want.command_byte)
          report_mismatch($sformatf("command_byte %h, want %h",
                                    out_ch.command_byte, want.command_byte));
        if (out_ch.button_bits !== want.button_bits)
          report_mismatch($sformatf("button_bits %h, want %h",
                                    out_ch.button_bits, want.button_bits));
        if (out_ch.move_x !== want.move_x)
          report_mismatch($sformatf("move_x %0d, want %0d", out_ch.move_x, want.move_x));
        if (out_ch.move_y !== want.move_y)
          report_mismatch($sformatf("move_y %0d, want %0d", out_ch.move_y, want.move_y));
        if (out_ch.move_wheel !== want.move_wheel)
          report_mismatch($sformatf("move_wheel %0d, want %0d",
                                    out_ch.move_wheel, want.move_wheel));
      end
    end
    if (in_fire) begin
      events_taken++;
      seen = '{in_ch.action, in_ch.rx_byte, in_ch.frame_status, in_ch.clock_high};
      host_step(seen, has, pred);
      if (has) due_results.push_back(pred);
    end
  end

  // stimulus building
  task automatic push_frame(input logic [7:0] b, input logic [1:0] fs);
    item_t e;
    e = '{ACT_BYTE, b, fs, 1'($urandom_range(1))};
    sess_q.push_back(e);
  endtask

  task automatic push_tick(input logic ch);
    item_t e;
    e = '{ACT_TICK, 8'($urandom_range(255)), 2'($urandom_range(3)), ch};
    sess_q.push_back(e);
  endtask

  function automatic item_t noise_item();
    item_t e;
    e = '{1'($urandom_range(1)), 8'($urandom_range(255)), 2'($urandom_range(3)),
          1'($urandom_range(1))};
    if ($urandom_range(1)) e.frame_status = FS_GOOD;
    return e;
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == avoid) b = b + 8'd1;
    return b;
  endfunction

  function automatic logic [7:0] move_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'h81;
      5: return 8'h01;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic flush_session();
    foreach (sess_q[i]) link_events.push_back(sess_q[i]);
    events_queued += sess_q.size();
    sess_q.delete();
  endtask

  // id byte, sometimes preceded by the ack of get-id
  task automatic push_id(input logic [7:0] id);
    if ($urandom_range(1)) push_frame(C_ACK, FS_GOOD);
    push_frame(id, FS_GOOD);
  endtask

  task automatic push_acks(input int n);
    repeat (n) push_frame(C_ACK, FS_GOOD);
  endtask

  // bring-up after a bad frame, with stray bytes at times, followed by a burst of packets
  task automatic build_session();
    int         nt;
    int         plen;
    int         k;
    bit         fires;
    logic [7:0] b0;
    push_frame(8'($urandom_range(255)), 2'($urandom_range(1, 3)));
    case ($urandom_range(9))
      0, 1: begin
        // idle clock watchdog fires or not, then self-test
        push_tick(1'b0);
        if (stall_lim <= 8'd20) begin
          nt = stall_lim + 1;
          fires = 1'b1;
        end else begin
          nt = $urandom_range(2, 8);
          fires = 1'b0;
        end
        repeat (nt) push_tick(1'b1);
        if (!fires) push_frame(C_ACK, FS_GOOD);
        push_acks(1);
      end
      2, 3: begin
        // unexpected byte forces a mouse reset
        push_frame(byte_other_than(C_BAT_OK), FS_GOOD);
        if ($urandom_range(1)) push_frame(byte_other_than(C_ACK), FS_GOOD);
        push_acks(1);
      end
      default: ;
    endcase
    push_frame(C_BAT_OK, FS_GOOD);
    // detection path
    case ($urandom_range(6))
      0: begin
        push_id(ID_STD); push_acks(6); push_id(ID_STD); plen = 3;
      end
      1: begin
        push_id(ID_STD); push_acks(6); push_id(ID_WHEEL); push_acks(6); push_id(ID_WHEEL);
        plen = 4;
      end
      2: begin
        push_id(ID_STD); push_acks(6); push_id(ID_WHEEL); push_acks(6); push_id(ID_FIVE);
        plen = 4;
      end
      3: begin
        push_id(ID_STD); push_acks(6); push_id(ID_WHEEL); push_acks(6); push_id(ID_STD);
        plen = 3;
      end
      4: begin
        push_id(ID_WHEEL); plen = 4;
      end
      5: begin
        push_id(ID_FIVE); plen = 4;
      end
      default: begin
        // knock cut short by a non-ack
        push_id(ID_STD);
        push_acks($urandom_range(5));
        push_frame(byte_other_than(C_ACK), FS_GOOD);
        plen = 3;
      end
    endcase
    // final setup with stray bytes
    for (k = 0; k < 6; k++) begin
      if ($urandom_range(99) < 15) push_frame(byte_other_than(C_ACK), FS_GOOD);
      push_frame(C_ACK, FS_GOOD);
    end
    // movement packets
    repeat ($urandom_range(2, 8)) begin
      b0 = 8'($urandom_range(255));
      if ($urandom_range(3) != 0) b0[7:6] = 2'b00;
      push_frame(b0, FS_GOOD);
      if ($urandom_range(9) == 0) push_tick(1'($urandom_range(1)));
      push_frame(move_byte(), FS_GOOD);
      push_frame(move_byte(), FS_GOOD);
      if (plen == 4) push_frame(8'($urandom_range(255)), FS_GOOD);
    end
  endtask

  task automatic queue_random(input int n);
    int cnt;
    int sel;
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(9);
      if (sel == 9) begin
        repeat ($urandom_range(6, 16)) sess_q.push_back(noise_item());
      end else begin
        build_session();
        if (sel >= 7) begin
          repeat ($urandom_range(1, 2))
            sess_q.insert($urandom_range(sess_q.size() - 1), noise_item());
        end
      end
      cnt += sess_q.size();
      flush_session();
    end
  endtask

  task automatic queue_directed();
    push_frame(8'h5A, FS_FRAMING);
    push_frame(8'hA5, FS_RESERVED);
    push_frame(8'h00, FS_PARITY);
    push_tick(1'b0);
    repeat (6) push_tick(1'b1);
    push_frame(8'h00, FS_GOOD);
    push_frame(C_ACK, FS_GOOD);
    push_frame(C_BAT_OK, FS_GOOD);
    push_frame(C_ACK, FS_GOOD);
    push_frame(8'h07, FS_GOOD);
    push_frame(C_ACK, FS_GOOD);
    push_frame(C_BAT_OK, FS_GOOD);
    push_frame(ID_FIVE, FS_GOOD);
    push_acks(6);
    // both signs set, largest magnitudes, all five buttons
    push_frame(8'h37, FS_GOOD);
    push_frame(8'h00, FS_GOOD);
    push_frame(8'h00, FS_GOOD);
    push_frame(8'h3F, FS_GOOD);
    flush_session();
  endtask

  // wait until every transaction is taken and every result has come back
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((events_taken != events_queued || due_results.size() != 0) && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    case (idx)
      CFG_STALL_LIMIT: stall_lim = val;
      CFG_RESOLUTION:  res_code = val[1:0];
      default:         rate_arg = val;
    endcase
  endtask

  // main sequence
  initial begin : stim
    int         p;
    logic [7:0] lim_v;
    logic [7:0] rate_v;
    logic [1:0] res_v;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_STALL_LIMIT;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_BYTE;
    in_ch.rx_byte      = '0;
    in_ch.frame_status = FS_GOOD;
    in_ch.clock_high   = 1'b0;
    out_ch.ready       = 1'b0;
    model_reset();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    queue_directed();
    for (p = 0; p < 8; p++) begin
      if (p != 0) begin
        // settings change only while the link is quiet
        wait_idle();
        rate_v = 8'($urandom_range(10, 200));
        res_v  = 2'($urandom_range(3));
        case (p)
          1: begin lim_v = 8'd0; res_v = 2'd0; rate_v = 8'd10; end
          2: begin lim_v = 8'd255; res_v = 2'd1; rate_v = 8'd200; end
          3: begin lim_v = 8'($urandom_range(1, 20)); res_v = 2'd2; end
          4: begin lim_v = 8'($urandom_range(255)); res_v = 2'd3; end
          5: lim_v = STALL_LIMIT_RST;
          6: lim_v = 8'($urandom_range(21, 254));
          default: lim_v = 8'($urandom_range(8));
        endcase
        write_reg(CFG_STALL_LIMIT, lim_v);
        write_reg(CFG_RESOLUTION, {6'd0, res_v});
        write_reg(CFG_REPORT_RATE, rate_v);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (p % 4)
          0: begin tx_idle_pct <= 0; rx_stall_pct <= 0; end
          1: begin tx_idle_pct <= 65; rx_stall_pct <= 0; end
          2: begin tx_idle_pct <= 0; rx_stall_pct <= 65; end
          default: begin tx_idle_pct <= 13; rx_stall_pct <= 13; end
        endcase
      end
      queue_random(110);
      // long receiver hold while the sender keeps offering
      if (p == 2) hold_go = 1'b1;
    end
    wait_idle();
    while (due_results.size() != 0) begin
      void'(due_results.pop_front());
      report_mismatch("expected result never arrived");
    end
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ps2m_pkg.sv
rtl/ps2m_if.sv
rtl/ps2m_in_reg.sv
rtl/ps2m_ctrl.sv
rtl/ps2m_out_reg.sv
rtl/ps2m_mouse_host_controller.sv
tb/ps2_mouse_host_controller_tb.sv
